// File: rtl/ber_pkg.sv
package ber_pkg;

   localparam int unsigned DEF_MAX_ROW_BITS = 1024;
   localparam int unsigned DEF_MAX_BYTES    = 1048576;

   localparam int unsigned ERR_W      = 24;
   localparam int unsigned RATE_W     = 18;
   localparam int unsigned Q_W        = 18;
   localparam int unsigned SCALE_W    = 15;
   localparam int unsigned NUM_W      = ERR_W + SCALE_W;
   localparam int unsigned RATE_SCALE = 25600;
   localparam int unsigned RATE_MAX   = 204800;
   localparam int unsigned CSR_W      = 11;
   localparam int unsigned CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_BITS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_STRIDE = 2'd2;

   typedef struct packed {
      logic byte_en;
      logic mult_en;
      logic load_en;
      logic step_en;
   } ber_cmd_type;

   function automatic logic [3:0] popcount8(input logic [7:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 8; i++) begin
         n = n + {3'd0, v[i]};
      end
      return n;
   endfunction

   // Keeps the k most significant bits of a byte, k from 1 to 8.
   function automatic logic [7:0] top_mask(input logic [3:0] k);
      logic [7:0] m;
      m = 8'd0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < k) begin
            m[7-i] = 1'b1;
         end
      end
      return m;
   endfunction

endpackage

// File: rtl/ber_ctrl.sv
module ber_ctrl
   import ber_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tlast,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output ber_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_CHECK,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   localparam int unsigned CNT_W = $clog2(Q_W);

   state_type        state_ff;
   logic [CNT_W-1:0] step_ff;
   logic             ready_ff;
   logic             valid_ff;
   logic             take;

   assign take        = req_tvalid & ready_ff;
   assign req_tready  = ready_ff;
   assign rsp_tvalid  = valid_ff;
   assign cmd.byte_en = take;
   assign cmd.mult_en = (state_ff == ST_MULT);
   assign cmd.load_en = (state_ff == ST_CHECK);
   assign cmd.step_en = (state_ff == ST_DIVIDE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         ready_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (take && req_tlast) begin
                  ready_ff <= 1'b0;
                  state_ff <= ST_MULT;
               end
            end
            ST_MULT: begin
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               step_ff  <= '0;
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               step_ff <= step_ff + CNT_W'(1);
               if (step_ff == CNT_W'(Q_W - 1)) begin
                  valid_ff <= 1'b1;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_tready) begin
                  valid_ff <= 1'b0;
                  ready_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// File: rtl/ber_dpath.sv
module ber_dpath
   import ber_pkg::*;
#(
   parameter int unsigned MAX_ROW_BITS = DEF_MAX_ROW_BITS,
   parameter int unsigned MAX_BYTES    = DEF_MAX_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ber_cmd_type          cmd,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic [7:0]           ref_byte,
   input  logic [7:0]           test_byte,
   input  logic                 last,
   output logic [ERR_W-1:0]     error_bits,
   output logic [RATE_W-1:0]    rate_percent_q8
);

   localparam int unsigned RB_W  = $clog2(MAX_ROW_BITS + 1);
   localparam int unsigned RBC_W = (RB_W > 11) ? RB_W : 11;
   localparam int unsigned BC_W  = $clog2(MAX_BYTES + 1);
   localparam int unsigned DIV_W = (2 * RB_W > BC_W) ? 2 * RB_W : BC_W;
   localparam int unsigned REM_W = DIV_W + 1;
   localparam int unsigned HI_W  = NUM_W - Q_W;
   localparam int unsigned CMP_W = (HI_W > DIV_W) ? HI_W : DIV_W;

   logic              row_mode_ff;
   logic [10:0]       row_bits_ff;
   logic [8:0]        stride_ff;

   logic [ERR_W-1:0]  err_ff;
   logic [RB_W-1:0]   col_ff;
   logic [7:0]        pos_ff;
   logic              skip_ff;
   logic [BC_W-1:0]   bcnt_ff;

   logic [ERR_W-1:0]  fin_err_ff;
   logic              fin_mode_ff;
   logic [RB_W-1:0]   fin_rb_ff;
   logic [BC_W-1:0]   fin_bcnt_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [DIV_W-1:0]  dvs_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [Q_W-1:0]    nlo_ff;
   logic [Q_W-1:0]    quot_ff;
   logic              sat_ff;

   logic [7:0]        diff;
   logic [RBC_W-1:0]  rbx;
   logic [RBC_W-1:0]  rb_eff;
   logic [RBC_W-1:0]  colx;
   logic [RBC_W-1:0]  rem_bits;
   logic [3:0]        k;
   logic [8:0]        stride_eff;
   logic [8:0]        pos_inc;
   logic              take;
   logic              row_end;
   logic [3:0]        add;
   logic [ERR_W:0]    err_sum;
   logic [ERR_W-1:0]  err_in;
   logic [RB_W-1:0]   col_in;
   logic              skip_in;
   logic [7:0]        pos_in;
   logic [BC_W-1:0]   bcnt_in;
   logic [DIV_W-1:0]  dvs_in;
   logic [HI_W-1:0]   num_hi;
   logic [REM_W:0]    trial;
   logic              fits;

   assign diff = ref_byte ^ test_byte;
   assign rbx  = RBC_W'(row_bits_ff);
   assign colx = RBC_W'(col_ff);

   always_comb begin
      priority if (rbx == '0) begin
         rb_eff = RBC_W'(1);
      end else if (rbx > RBC_W'(MAX_ROW_BITS)) begin
         rb_eff = RBC_W'(MAX_ROW_BITS);
      end else begin
         rb_eff = rbx;
      end
      priority if (stride_ff == 9'd0) begin
         stride_eff = 9'd1;
      end else if (stride_ff > 9'd256) begin
         stride_eff = 9'd256;
      end else begin
         stride_eff = stride_ff;
      end
   end

   always_comb begin
      rem_bits = (colx >= rb_eff) ? '0 : rb_eff - colx;
      row_end  = (rem_bits <= RBC_W'(8));
      k        = (rem_bits == '0) ? 4'd1 : rem_bits[3:0];
      take     = !(skip_ff && (pos_ff != 8'd0));
      add      = '0;
      col_in   = col_ff;
      skip_in  = skip_ff;
      if (row_mode_ff) begin
         if (take) begin
            if (row_end) begin
               add     = popcount8(diff & top_mask(k));
               col_in  = '0;
               skip_in = 1'b1;
            end else begin
               add     = popcount8(diff);
               col_in  = col_ff + RB_W'(8);
               skip_in = 1'b0;
            end
         end
      end else begin
         add = popcount8(diff);
      end
      err_sum = {1'b0, err_ff} + (ERR_W + 1)'(add);
      err_in  = err_sum[ERR_W] ? '1 : err_sum[ERR_W-1:0];
      bcnt_in = (bcnt_ff < BC_W'(MAX_BYTES)) ? bcnt_ff + BC_W'(1) : bcnt_ff;
      pos_inc = {1'b0, pos_ff} + 9'd1;
      pos_in  = (pos_inc >= stride_eff) ? 8'd0 : pos_inc[7:0];
   end

   always_comb begin
      if (fin_mode_ff) begin
         dvs_in = DIV_W'(fin_rb_ff) * DIV_W'(fin_rb_ff);
      end else begin
         dvs_in = DIV_W'(fin_bcnt_ff);
      end
      if (dvs_in == '0) begin
         dvs_in = DIV_W'(1);
      end
      num_hi = num_ff[NUM_W-1:Q_W];
      trial  = {rem_ff, nlo_ff[Q_W-1]};
      fits   = (trial >= (REM_W + 1)'(dvs_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_mode_ff <= 1'b0;
         row_bits_ff <= 11'd64;
         stride_ff   <= 9'd8;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROW_MODE:   row_mode_ff <= csr_wdata[0];
            CSR_ROW_BITS:   row_bits_ff <= csr_wdata[10:0];
            CSR_ROW_STRIDE: stride_ff   <= csr_wdata[8:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff  <= '0;
         col_ff  <= '0;
         pos_ff  <= '0;
         skip_ff <= 1'b0;
         bcnt_ff <= '0;
      end else if (cmd.byte_en) begin
         if (last) begin
            err_ff  <= '0;
            col_ff  <= '0;
            pos_ff  <= '0;
            skip_ff <= 1'b0;
            bcnt_ff <= '0;
         end else begin
            err_ff  <= err_in;
            col_ff  <= col_in;
            pos_ff  <= pos_in;
            skip_ff <= skip_in;
            bcnt_ff <= bcnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.byte_en && last) begin
         fin_err_ff  <= err_in;
         fin_mode_ff <= row_mode_ff;
         fin_rb_ff   <= RB_W'(rb_eff);
         fin_bcnt_ff <= bcnt_in;
      end
      if (cmd.mult_en) begin
         num_ff <= NUM_W'(fin_err_ff) * NUM_W'(RATE_SCALE);
         dvs_ff <= dvs_in;
      end
      if (cmd.load_en) begin
         sat_ff  <= (CMP_W'(num_hi) >= CMP_W'(dvs_ff));
         rem_ff  <= REM_W'(num_hi);
         nlo_ff  <= num_ff[Q_W-1:0];
         quot_ff <= '0;
      end
      if (cmd.step_en) begin
         if (fits) begin
            rem_ff <= REM_W'(trial - (REM_W + 1)'(dvs_ff));
         end else begin
            rem_ff <= REM_W'(trial);
         end
         nlo_ff  <= {nlo_ff[Q_W-2:0], 1'b0};
         quot_ff <= {quot_ff[Q_W-2:0], fits};
      end
   end

   assign error_bits = fin_err_ff;

   always_comb begin
      if (sat_ff || (quot_ff > Q_W'(RATE_MAX))) begin
         rate_percent_q8 = RATE_W'(RATE_MAX);
      end else begin
         rate_percent_q8 = RATE_W'(quot_ff);
      end
   end

endmodule

// File: rtl/bit_error_rate_with_row_padding.sv
// Counts differing bits between a reference and a test byte stream, most significant bit
// first, optionally limited to rows of row_bits bits stored in padded rows of
// row_stride_bytes bytes. Ordinary byte pairs are taken at one per cycle. The pair marked
// with tlast ends the data set and yields one transfer holding the error count and the
// error percentage in Q8, once the rate multiply, the range check and the one-bit-per-cycle
// divider have run in that order. No further input is taken after that last pair until the
// result transfer completes. Configuration should be written only while idle.
module bit_error_rate_with_row_padding
   import ber_pkg::*;
#(
   parameter int unsigned MAX_ROW_BITS = DEF_MAX_ROW_BITS,
   parameter int unsigned MAX_BYTES    = DEF_MAX_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,  // ref_byte, test_byte
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [47:0]          rsp_tdata,  // error_bits, rate_percent_q8, zero fill
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   ber_cmd_type         cmd;
   logic [ERR_W-1:0]    error_bits;
   logic [RATE_W-1:0]   rate_percent_q8;

   ber_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ber_dpath #(
      .MAX_ROW_BITS (MAX_ROW_BITS),
      .MAX_BYTES    (MAX_BYTES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .ref_byte        (req_tdata[7:0]),
      .test_byte       (req_tdata[15:8]),
      .last            (req_tlast),
      .error_bits      (error_bits),
      .rate_percent_q8 (rate_percent_q8)
   );

   assign rsp_tdata = {6'd0, rate_percent_q8, error_bits};

endmodule

// File: tb/bit_error_rate_with_row_padding_tb.sv
`timescale 1ns / 1ps

module bit_error_rate_with_row_padding_tb;
   import ber_pkg::*;

   localparam int unsigned RANDOM_PAIRS     = 1950;
   localparam int unsigned SETTLE_CYCLES    = 24;
   localparam int unsigned DRAIN_CYCLES     = 40;
   localparam int unsigned LONG_HOLD_CYCLES = 300;
   localparam int unsigned ERR_LIMIT        = (1 << ERR_W) - 1;
   localparam int unsigned SCRIPT_LEN       = 32;

   typedef struct packed {
      logic [ERR_W-1:0]  error_bits;
      logic [RATE_W-1:0] rate_q8;
   } ber_result_type;

   typedef enum logic {STEP_PAIR, STEP_CSR} step_kind_type;

   typedef enum int unsigned {FILL_RANDOM, FILL_SPARSE, FILL_INVERTED, FILL_EQUAL} fill_kind_type;

   typedef struct packed {
      step_kind_type         kind;
      logic [7:0]            ref_b;
      logic [7:0]            tst_b;
      logic                  last_b;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_W-1:0]      csr_val;
      logic                  typed;
      logic [ERR_W-1:0]      want_err;
      logic [RATE_W-1:0]     want_rate;
   } script_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata = 16'd0;  // ref_byte, test_byte
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b1;
   logic [47:0]          rsp_tdata;          // error_bits, rate_percent_q8, zero fill
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ROW_MODE;
   logic [CSR_W-1:0]     csr_wdata = '0;

   logic                 cfg_row_mode = 1'b0;
   logic [10:0]          cfg_row_bits = 11'd64;
   logic [8:0]           cfg_stride = 9'd8;

   logic [ERR_W-1:0]     err_sum = '0;
   logic [10:0]          col_bits = '0;
   logic [7:0]           stride_pos = '0;
   logic                 in_padding = 1'b0;
   logic [20:0]          pair_count = '0;

   ber_result_type       pending_results[$];
   int unsigned          failures = 0;
   bit                   sender_steady = 1'b0;
   bit                   receiver_steady = 1'b0;
   bit                   hold_armed = 1'b0;

   script_row_type directed_script [SCRIPT_LEN] = '{
      '{STEP_PAIR, 8'hFF, 8'h00, 1'b1, CSR_ROW_MODE, 11'd0, 1'b1, 24'd8, 18'd204800},
      '{STEP_PAIR, 8'h00, 8'h00, 1'b1, CSR_ROW_MODE, 11'd0, 1'b1, 24'd0, 18'd0},
      '{STEP_PAIR, 8'h0F, 8'h00, 1'b0, CSR_ROW_MODE, 11'd0, 1'b0, 24'd0, 18'd0},
      '{STEP_PAIR, 8'hF0, 8'h00, 1'b1, CSR_ROW_MODE, 11'd0, 1'b1, 24'd8, 18'd102400},
      '{STEP_PAIR, 8'h01, 8'h00, 1'b1, CSR_ROW_MODE, 11'd0, 1'b1, 24'd1, 18'd25600},
      '{STEP_PAIR, 8'h00, 8'hFF, 1'b1, CSR_ROW_MODE, 11'd0, 1'b1, 24'd8, 18'd204800},
      '{STEP_CSR,  8'h00, 8'h00, 1'b0, CSR_ROW_MODE, 11'd1, 1'b0, 24'd0, 18'd0},
      '{STEP_CSR,  8'h00, 8'h00, 1'b0, CSR_ROW_BITS, 11'd0, 1'b0, 24'd0, 18'd0},
      '{STEP_CSR,  8'h00, 8'h00, 1'b0, CSR_ROW_STRIDE, 11'd0, 1'b0, 24'd0, 18'd0},
      '{STEP_PAIR, 8'hFF, 8'h00, 1'b0, CSR_ROW_MODE, 11'd0, 1'b0, 24'd0, 18'd0},
      '{STEP_PAIR, 8'hFF, 8'h00, 1'b0, CSR_ROW_MODE, 11'd0, 1'b0, 24'd0, 18'd0},
      '{STEP_PAIR, 8'hFF, 8'h00, 1'b0, CSR_ROW_MODE, 11'd0, 1'b0, 24'd0, 18'd0},
      '{STEP_PAIR, 8'hFF, 8'h00, 1'b0, CSR_ROW_MODE, 11'd0, 1'b0, 24'd0, 18'd0},
      '{STEP_PAIR, 8'hFF, 8'h00, 1'b0, CSR_ROW_MODE, 11'd0, 1'b0, 24'd0, 18'd0},
      '{STEP_PAIR, 8'hFF, 8'h00, 1'b0, CSR_ROW_MODE, 11'd0, 1'b0, 24'd0, 18'd0},
      '{STEP_PAIR, 8'hFF, 8'h00, 1'b0, CSR_ROW_MODE, 11'd0, 1'b0, 24'd0, 18'd0},
      '{STEP_PAIR, 8'hFF, 8'h00, 1'b0, CSR_ROW_MODE, 11'd0, 1'b0, 24'd0, 18'd0},
      '{STEP_PAIR, 8'hFF, 8'h00, 1'b1, CSR_ROW_MODE, 11'd0, 1'b1, 24'd9, 18'd204800},
      '{STEP_CSR,  8'h00, 8'h00, 1'b0, CSR_ROW_BITS, 11'd2047, 1'b0, 24'd0, 18'd0},
      '{STEP_CSR,  8'h00, 8'h00, 1'b0, CSR_ROW_STRIDE, 11'd511, 1'b0, 24'd0, 18'd0},
      '{STEP_PAIR, 8'h00, 8'hFF, 1'b1, CSR_ROW_MODE, 11'd0, 1'b1, 24'd8, 18'd0},
      '{STEP_CSR,  8'h00, 8'h00, 1'b0, CSR_ROW_BITS, 11'd12, 1'b0, 24'd0, 18'd0},
      '{STEP_CSR,  8'h00, 8'h00, 1'b0, CSR_ROW_STRIDE, 11'd3, 1'b0, 24'd0, 18'd0},
      '{STEP_PAIR, 8'hFF, 8'h00, 1'b0, CSR_ROW_MODE, 11'd0, 1'b0, 24'd0, 18'd0},
      '{STEP_PAIR, 8'hFF, 8'h00, 1'b0, CSR_ROW_MODE, 11'd0, 1'b0, 24'd0, 18'd0},
      '{STEP_PAIR, 8'hFF, 8'h00, 1'b0, CSR_ROW_MODE, 11'd0, 1'b0, 24'd0, 18'd0},
      '{STEP_PAIR, 8'hFF, 8'h00, 1'b1, CSR_ROW_MODE, 11'd0, 1'b0, 24'd0, 18'd0},
      '{STEP_PAIR, 8'hFF, 8'h00, 1'b0, CSR_ROW_MODE, 11'd0, 1'b0, 24'd0, 18'd0},
      '{STEP_CSR,  8'h00, 8'h00, 1'b0, CSR_ROW_BITS, 11'd5, 1'b0, 24'd0, 18'd0},
      '{STEP_PAIR, 8'hFF, 8'h00, 1'b1, CSR_ROW_MODE, 11'd0, 1'b0, 24'd0, 18'd0},
      '{STEP_CSR,  8'h00, 8'h00, 1'b0, CSR_ROW_MODE, 11'd0, 1'b0, 24'd0, 18'd0},
      '{STEP_PAIR, 8'h3C, 8'hC3, 1'b1, CSR_ROW_MODE, 11'd0, 1'b0, 24'd0, 18'd0}
   };

   bit_error_rate_with_row_padding u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned effective_row_bits();
      if (cfg_row_bits == 0) return 1;
      if (cfg_row_bits > DEF_MAX_ROW_BITS) return DEF_MAX_ROW_BITS;
      return cfg_row_bits;
   endfunction

   function automatic int unsigned effective_stride();
      if (cfg_stride == 0) return 1;
      if (cfg_stride > 256) return 256;
      return cfg_stride;
   endfunction

   // Updates the running error tally with one byte pair; returns 1 when a result is due.
   function automatic bit tally_byte_pair(input logic [7:0] ref_b, input logic [7:0] tst_b,
                                          input logic last_b, output ber_result_type res);
      logic [7:0]        diff;
      logic [7:0]        mask;
      bit                take;
      int unsigned       rb;
      int unsigned       stride;
      int unsigned       left;
      int unsigned       keep;
      int unsigned       add;
      int unsigned       total;
      int unsigned       next_pos;
      longint unsigned   divisor;
      longint unsigned   rate;
      diff = ref_b ^ tst_b;
      rb = effective_row_bits();
      stride = effective_stride();
      add = 0;
      res = '0;
      if (cfg_row_mode) begin
         take = 1'b1;
         if (in_padding) begin
            if (stride_pos == 0) in_padding = 1'b0;
            else take = 1'b0;
         end
         if (take) begin
            left = (col_bits >= rb) ? 0 : rb - col_bits;
            if (left <= 8) begin
               keep = (left == 0) ? 1 : left;
               mask = 8'hFF << (8 - keep);
               add = $countones(diff & mask);
               col_bits = '0;
               in_padding = 1'b1;
            end else begin
               add = $countones(diff);
               col_bits = col_bits + 11'd8;
            end
         end
      end else begin
         add = $countones(diff);
      end
      total = err_sum + add;
      err_sum = (total > ERR_LIMIT) ? ERR_LIMIT[ERR_W-1:0] : total[ERR_W-1:0];
      if (pair_count < DEF_MAX_BYTES) pair_count = pair_count + 21'd1;
      next_pos = stride_pos + 1;
      stride_pos = (next_pos >= stride) ? 8'd0 : next_pos[7:0];
      if (!last_b) return 1'b0;
      divisor = cfg_row_mode ? 64'(rb) * 64'(rb) : 64'(pair_count);
      if (divisor == 0) divisor = 1;
      rate = 64'(err_sum) * RATE_SCALE / divisor;
      if (rate > RATE_MAX) rate = RATE_MAX;
      res.error_bits = err_sum;
      res.rate_q8 = rate[RATE_W-1:0];
      err_sum = '0;
      col_bits = '0;
      stride_pos = '0;
      in_padding = 1'b0;
      pair_count = '0;
      return 1'b1;
   endfunction

   function automatic int unsigned gap_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_ROW_MODE:   cfg_row_mode = val[0];
         CSR_ROW_BITS:   cfg_row_bits = val[10:0];
         CSR_ROW_STRIDE: cfg_stride = val[8:0];
         default: ;
      endcase
   endtask

   task automatic send_pair(input logic [7:0] ref_b, input logic [7:0] tst_b,
                            input logic last_b, input logic typed,
                            input logic [ERR_W-1:0] want_err,
                            input logic [RATE_W-1:0] want_rate);
      ber_result_type res;
      int unsigned    gap;
      req_tvalid <= 1'b1;
      req_tdata <= {tst_b, ref_b};
      req_tlast <= last_b;
      do @(posedge clock); while (!req_tready);
      if (tally_byte_pair(ref_b, tst_b, last_b, res)) begin
         if (typed) begin
            res.error_bits = want_err;
            res.rate_q8 = want_rate;
         end
         pending_results.push_back(res);
      end
      gap = sender_steady ? 0 : gap_length();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      ber_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with nothing expected: tdata %h", rsp_tdata);
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[ERR_W-1:0] !== want.error_bits) begin
               $error("error_bits: expected %0d, got %0d", want.error_bits,
                      rsp_tdata[ERR_W-1:0]);
               failures++;
            end
            if (rsp_tdata[ERR_W +: RATE_W] !== want.rate_q8) begin
               $error("rate_percent_q8: expected %0d, got %0d", want.rate_q8,
                      rsp_tdata[ERR_W +: RATE_W]);
               failures++;
            end
         end
      end
   end

   initial begin
      int unsigned hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold != 0) begin
            hold--;
            if (hold == 0 && !hold_armed) rsp_tready <= 1'b1;
         end else if (hold_armed) begin
            rsp_tready <= 1'b0;
            if (rsp_tvalid) begin
               hold_armed = 1'b0;
               hold = LONG_HOLD_CYCLES;
            end
         end else if (!receiver_steady && $urandom_range(0, 3) == 0) begin
            hold = gap_length() + 1;
            rsp_tready <= 1'b0;
         end
      end
   end

   initial begin
      #16_000_000;
      $display("bit_error_rate_with_row_padding regression: fail");
      $finish;
   end

   initial begin
      int unsigned    random_pairs;
      int unsigned    phase;
      int unsigned    sets;
      int unsigned    set_len;
      int unsigned    rows;
      int unsigned    pick;
      int unsigned    rb_now;
      int unsigned    stride_min;
      logic [10:0]    rb_val;
      logic [8:0]     stride_val;
      logic [7:0]     a;
      logic [7:0]     b;
      fill_kind_type  fill;
      script_row_type row;
      random_pairs = 0;
      phase = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < SCRIPT_LEN; i++) begin
         row = directed_script[i];
         if (row.kind == STEP_CSR) write_csr(row.csr_idx, row.csr_val);
         else send_pair(row.ref_b, row.tst_b, row.last_b, row.typed, row.want_err,
                        row.want_rate);
      end

      while (random_pairs < RANDOM_PAIRS) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) rb_val = 11'd0;
         else if (pick < 14) rb_val = 11'd2047;
         else if (pick < 20) rb_val = 11'd1024;
         else if (pick < 24) rb_val = 11'($urandom_range(1025, 2047));
         else if (pick < 36) rb_val = 11'($urandom_range(25, 200));
         else rb_val = 11'($urandom_range(1, 24));
         write_csr(CSR_ROW_BITS, rb_val);
         rb_now = effective_row_bits();
         stride_min = (rb_now + 7) / 8;
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            stride_val = 9'(stride_min + $urandom_range(0, 3));
         end else if (pick < 78) stride_val = 9'd0;
         else if (pick < 84) stride_val = 9'd511;
         else if (pick < 90) stride_val = 9'd256;
         else stride_val = 9'($urandom_range(0, 511));
         write_csr(CSR_ROW_STRIDE, {2'b00, stride_val});
         write_csr(CSR_ROW_MODE, 11'($urandom_range(0, 9) < 6));
         sender_steady = (phase == 2) || ($urandom_range(0, 4) == 0);
         receiver_steady = ($urandom_range(0, 4) == 0);
         if (phase == 2) hold_armed = 1'b1;
         sets = $urandom_range((phase == 2) ? 2 : 1, 4);
         for (int s = 0; s < sets; s++) begin
            if (cfg_row_mode && $urandom_range(0, 3) != 0) begin
               rows = (rb_now <= 12) ? rb_now : $urandom_range(1, (rb_now > 64) ? 2 : 6);
               set_len = rows * effective_stride();
               if (set_len > 520) set_len = 520;
            end else if ($urandom_range(0, 99) < 85) begin
               set_len = $urandom_range(1, 24);
            end else begin
               set_len = $urandom_range(25, 300);
            end
            fill = fill_kind_type'($urandom_range(0, 3));
            for (int i = 0; i < set_len; i++) begin
               a = 8'($urandom);
               case (fill)
                  FILL_RANDOM:   b = 8'($urandom);
                  FILL_SPARSE:   b = ($urandom_range(0, 5) == 0) ?
                                     a ^ (8'd1 << $urandom_range(0, 7)) : a;
                  FILL_INVERTED: b = ~a;
                  default:       b = a;
               endcase
               if (set_len > 4 && i == set_len / 2 && $urandom_range(0, 7) == 0) begin
                  pick = $urandom_range(0, 2);
                  if (pick == 0) write_csr(CSR_ROW_MODE, 11'($urandom_range(0, 1)));
                  else if (pick == 1) write_csr(CSR_ROW_BITS, 11'($urandom_range(1, 40)));
                  else write_csr(CSR_ROW_STRIDE, 11'($urandom_range(1, 12)));
               end
               send_pair(a, b, i == set_len - 1, 1'b0, '0, '0);
               random_pairs++;
            end
            if (phase == 4) begin
               req_tvalid <= 1'b0;
               wait_drained();
            end
         end
         phase++;
      end

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("bit_error_rate_with_row_padding regression: pass");
      end else begin
         $display("bit_error_rate_with_row_padding regression: fail");
      end
      $finish;
   end

endmodule
